### hw/rtl/tecm_pkg.sv
// Shared types and constants of the two-ended coincidence matcher.
// Used by tecm_cell, tecm_hit_calc and two_ended_coincidence_matcher.
// No dependencies.
package tecm_pkg;

   // Pending queue depth (cells in the chain)
   localparam int PENDING_DEPTH = 16;

   localparam int TIME_W     = 48;
   localparam int TOT_W      = 20;
   localparam int SUM_TOT_W  = TOT_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_WINDOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOF_ADJUST     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_VELOCITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOT_GAIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOT_OFFSET     = 3'd4;

   // Q8.16 unity gain
   localparam logic [23:0] TOT_GAIN_RESET = 24'd65536;

   // Operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD     = 3'd0,
      CELL_EVAL     = 3'd1,  // clear entries at or past the window
      CELL_SHIFT    = 3'd2,  // close the lowest hole
      CELL_POP      = 3'd3,  // remove the head
      CELL_PUSH     = 3'd4,  // append at the first free cell
      CELL_POP_PUSH = 3'd5,  // full queue: remove head and append at the tail
      CELL_FLUSH    = 3'd6   // empty the queue
   } cell_op_type;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] time_ps;
      logic [TOT_W-1:0]  tot;
   } entry_type;

   typedef struct packed {
      cell_op_type       op;
      logic [TIME_W-1:0] item_time;
      logic [TOT_W-1:0]  item_tot;
      logic [23:0]       window;
   } cell_ctrl_type;

   typedef struct packed {
      logic [23:0] match_window;
      logic [23:0] tof_adjust;
      logic [15:0] light_velocity;
      logic [23:0] tot_gain;
      logic [23:0] tot_offset;
   } cfg_type;

   // Operands of one matched pair
   typedef struct packed {
      logic [TIME_W-1:0]    ta;
      logic [TIME_W-1:0]    tb;
      logic [SUM_TOT_W-1:0] sum_tot;
   } pair_type;

endpackage

### hw/rtl/two_ended_coincidence_matcher.sv
// Top level of the two-ended coincidence matcher: chain of pending cells,
// control sequencer, configuration registers and the hit pipeline.
// Depends on tecm_pkg, tecm_cell and tecm_hit_calc.
//
//   channel | ports  | direction | moves
//   --------+--------+-----------+-------------------------------------------
//   input   | req_*  | in        | one signal: time, end, TOT, group end flag
//   result  | rsp_*  | out       | one hit: time, end difference, TOT, position
//   config  | csr_*  | in        | one register write: index and data
//
// For each item the age compare in every cell runs at the accepting edge; then the
// chain closes holes and pops, appends or flushes. An expired entry that leaves
// a hole below a live entry delays the item, as the chain closes one hole a cycle.
// A pair waits while the hit pipeline is full; a taken pair passes its A, B, C
// and output registers. Reset is synchronous and empties the queue at once.
module two_ended_coincidence_matcher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [47:0]                       req_signal_time,
   input  logic                              req_signal_end,
   input  logic [19:0]                       req_signal_tot,
   input  logic                              req_group_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [48:0]                rsp_hit_time,
   output logic signed [24:0]                rsp_end_time_difference,
   output logic signed [31:0]                rsp_hit_tot,
   output logic signed [31:0]                rsp_axial_position,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tecm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tecm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int Depth = tecm_pkg::PENDING_DEPTH;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SETTLE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   tecm_pkg::cfg_type cfg_ff, cfg_in;

   logic [tecm_pkg::TIME_W-1:0] item_time_ff;
   logic                        item_end_ff;
   logic [tecm_pkg::TOT_W-1:0]  item_tot_ff;
   logic                        item_group_end_ff;
   logic                        pend_end_ff, pend_end_in;

   tecm_pkg::cell_ctrl_type ctrl;
   tecm_pkg::entry_type     cell_entry [Depth];
   logic [Depth-1:0]        cell_valid;
   logic [Depth-1:0]        misplaced;
   logic [Depth:0]          hole;

   logic               misplaced_any;
   logic               pair;
   logic               act;
   logic               settle_act;
   logic               calc_ready;
   logic               calc_valid;
   tecm_pkg::pair_type calc_pair;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tecm_pkg::CSR_MATCH_WINDOW:   cfg_in.match_window   = csr_data;
            tecm_pkg::CSR_TOF_ADJUST:     cfg_in.tof_adjust     = csr_data;
            tecm_pkg::CSR_LIGHT_VELOCITY: cfg_in.light_velocity = csr_data[15:0];
            tecm_pkg::CSR_TOT_GAIN:       cfg_in.tot_gain       = csr_data;
            tecm_pkg::CSR_TOT_OFFSET:     cfg_in.tot_offset     = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Queue status from the chain
   assign misplaced_any = |misplaced;
   assign pair          = cell_valid[0] & (item_end_ff != pend_end_ff);
   assign act           = ~misplaced_any & (~pair | calc_ready);
   assign settle_act    = (state_ff == ST_SETTLE) & act;

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence: compare ages on transfer, then close holes, then act
   always_comb begin
      state_in    = state_ff;
      pend_end_in = pend_end_ff;
      ctrl.op     = tecm_pkg::CELL_HOLD;
      // The compare uses the port time at the accepting edge, the held item later
      ctrl.item_time = (state_ff == ST_IDLE) ? req_signal_time : item_time_ff;
      ctrl.item_tot  = item_tot_ff;
      ctrl.window    = cfg_ff.match_window;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.op  = tecm_pkg::CELL_EVAL;
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            if (misplaced_any) begin
               ctrl.op = tecm_pkg::CELL_SHIFT;
            end else if (act) begin
               state_in = ST_IDLE;
               if (!pair) begin
                  pend_end_in = item_end_ff;
               end
               if (item_group_end_ff) begin
                  ctrl.op = tecm_pkg::CELL_FLUSH;
               end else if (pair) begin
                  ctrl.op = tecm_pkg::CELL_POP;
               end else if (cell_valid[Depth-1]) begin
                  ctrl.op = tecm_pkg::CELL_POP_PUSH;
               end else begin
                  ctrl.op = tecm_pkg::CELL_PUSH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Chain of pending cells, head at index 0
   assign hole[0] = 1'b0;

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      tecm_pkg::entry_type upper;
      logic                lower_valid;

      if (i == Depth - 1) begin : g_tail
         assign upper = '0;
      end else begin : g_body
         assign upper = cell_entry[i+1];
      end

      if (i == 0) begin : g_head
         assign lower_valid = 1'b1;
      end else begin : g_rest
         assign lower_valid = cell_valid[i-1];
      end

      tecm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .upper       (upper),
         .lower_valid (lower_valid),
         .hole_in     (hole[i]),
         .entry       (cell_entry[i]),
         .hole_out    (hole[i+1]),
         .misplaced   (misplaced[i])
      );

      assign cell_valid[i] = cell_entry[i].valid;
   end

   // Pair operands: the oldest pending signal and the held item
   assign calc_valid = settle_act & pair;
   assign calc_pair  = {item_end_ff ? cell_entry[0].time_ps : item_time_ff,
                        item_end_ff ? item_time_ff : cell_entry[0].time_ps,
                        {1'b0, item_tot_ff} + {1'b0, cell_entry[0].tot}};

   tecm_hit_calc u_hit_calc (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg_ff),
      .pair_valid              (calc_valid),
      .pair                    (calc_pair),
      .pair_ready              (calc_ready),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_hit_time            (rsp_hit_time),
      .rsp_end_time_difference (rsp_end_time_difference),
      .rsp_hit_tot             (rsp_hit_tot),
      .rsp_axial_position      (rsp_axial_position)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= ST_IDLE;
         pend_end_ff             <= 1'b0;
         cfg_ff.match_window     <= '0;
         cfg_ff.tof_adjust       <= '0;
         cfg_ff.light_velocity   <= '0;
         cfg_ff.tot_gain         <= tecm_pkg::TOT_GAIN_RESET;
         cfg_ff.tot_offset       <= '0;
      end else begin
         state_ff    <= state_in;
         pend_end_ff <= pend_end_in;
         cfg_ff      <= cfg_in;
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_time_ff      <= req_signal_time;
         item_end_ff       <= req_signal_end;
         item_tot_ff       <= req_signal_tot;
         item_group_end_ff <= req_group_end;
      end
   end

   // The queue is compact whenever a new signal may be taken
   a_compact_in_idle : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !misplaced_any)
      else $error("pending queue has a hole while idle");

   // An append without flush leaves the head occupied
   a_append_fills : assert property (@(posedge clock) disable iff (reset)
      settle_act && !pair && !item_group_end_ff |=> cell_valid[0])
      else $error("append left the queue empty");

   // A pair without flush removes exactly one pending entry
   a_pair_pops_one : assert property (@(posedge clock) disable iff (reset)
      settle_act && pair && !item_group_end_ff
      |=> $countones(cell_valid) == $past($countones(cell_valid)) - 1)
      else $error("pairing did not remove exactly one entry");

   // Group end empties the queue
   a_flush_empties : assert property (@(posedge clock) disable iff (reset)
      settle_act && item_group_end_ff |=> cell_valid == '0)
      else $error("group end left pending entries");

endmodule

### hw/rtl/tecm_cell.sv
// One cell of the pending-signal chain: holds one queue entry, checks its age
// and hands its entry to the lower neighbor on shift, pop and pop-push.
// Depends on tecm_pkg.
module tecm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tecm_pkg::cell_ctrl_type ctrl,
   input  tecm_pkg::entry_type    upper,
   input  logic                   lower_valid,
   input  logic                   hole_in,
   output tecm_pkg::entry_type    entry,
   output logic                   hole_out,
   output logic                   misplaced
);

   logic                        valid_ff, valid_in;
   logic [tecm_pkg::TIME_W-1:0] time_ff, time_in;
   logic [tecm_pkg::TOT_W-1:0]  tot_ff, tot_in;
   logic signed [tecm_pkg::TIME_W:0] age;
   logic                        keep;

   // Age against the arriving signal; a negative age stays inside the window
   assign age  = $signed({1'b0, ctrl.item_time}) - $signed({1'b0, time_ff});
   assign keep = age[tecm_pkg::TIME_W]
                 | (age[tecm_pkg::TIME_W-1:0] < {24'b0, ctrl.window});

   // Hole at or below this cell; a valid entry above a hole must move down
   assign hole_out  = hole_in | ~valid_ff;
   assign misplaced = valid_ff & hole_in;

   // Select next entry
   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      tot_in   = tot_ff;
      unique case (ctrl.op)
         tecm_pkg::CELL_HOLD: begin
         end
         tecm_pkg::CELL_EVAL: begin
            valid_in = valid_ff & keep;
         end
         tecm_pkg::CELL_SHIFT: begin
            if (hole_out) begin
               valid_in = upper.valid;
               time_in  = upper.time_ps;
               tot_in   = upper.tot;
            end
         end
         tecm_pkg::CELL_POP: begin
            valid_in = upper.valid;
            time_in  = upper.time_ps;
            tot_in   = upper.tot;
         end
         tecm_pkg::CELL_PUSH: begin
            if (!valid_ff && lower_valid) begin
               valid_in = 1'b1;
               time_in  = ctrl.item_time;
               tot_in   = ctrl.item_tot;
            end
         end
         tecm_pkg::CELL_POP_PUSH: begin
            // only the tail cell sees an empty upper neighbor on a full queue
            if (upper.valid) begin
               valid_in = 1'b1;
               time_in  = upper.time_ps;
               tot_in   = upper.tot;
            end else begin
               valid_in = 1'b1;
               time_in  = ctrl.item_time;
               tot_in   = ctrl.item_tot;
            end
         end
         tecm_pkg::CELL_FLUSH: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tot_ff  <= tot_in;
   end

   assign entry = {valid_ff, time_ff, tot_ff};

endmodule

### hw/rtl/tecm_hit_calc.sv
// Hit arithmetic pipeline: mean time, end time difference, calibrated TOT and
// axial position of one matched pair, with an output register on rsp_.
// Depends on tecm_pkg.
module tecm_hit_calc (
   input  logic                      clock,
   input  logic                      reset,
   input  tecm_pkg::cfg_type         cfg,
   input  logic                      pair_valid,
   input  tecm_pkg::pair_type        pair,
   output logic                      pair_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [48:0]        rsp_hit_time,
   output logic signed [24:0]        rsp_end_time_difference,
   output logic signed [31:0]        rsp_hit_tot,
   output logic signed [31:0]        rsp_axial_position
);

   // stage valids and readiness
   logic a_valid_ff, b_valid_ff, c_valid_ff, out_valid_ff;
   logic a_ready, b_ready, c_ready, out_ready;

   tecm_pkg::pair_type a_ff;

   logic [48:0]                    b_time_ff, b_time_in;
   logic [24:0]                    b_diff_ff, b_diff_in;
   logic [tecm_pkg::SUM_TOT_W-1:0] b_sum_tot_ff;

   logic [48:0]        c_time_ff;
   logic [24:0]        c_diff_ff;
   logic [44:0]        c_tot_prod_ff, c_tot_prod_in;
   logic signed [41:0] c_pos_prod_ff, c_pos_prod_in;

   logic [48:0] out_time_ff;
   logic [24:0] out_diff_ff;
   logic [31:0] out_tot_ff, out_tot_in;
   logic [31:0] out_pos_ff, out_pos_in;

   logic [48:0]        sum_t;
   logic [47:0]        mean_t;
   logic signed [49:0] time_wide;
   logic [48:0]        diff_wide;
   logic [27:0]        tot_shift;
   logic [32:0]        pos_shift;

   assign out_ready  = ~out_valid_ff | rsp_ready;
   assign c_ready    = ~c_valid_ff | out_ready;
   assign b_ready    = ~b_valid_ff | c_ready;
   assign a_ready    = ~a_valid_ff | b_ready;
   assign pair_ready = a_ready;

   // Mean time minus TOF correction, and B minus A, both saturated
   always_comb begin
      sum_t     = {1'b0, a_ff.ta} + {1'b0, a_ff.tb};
      mean_t    = sum_t[48:1];
      time_wide = $signed({2'b00, mean_t}) - $signed({{26{cfg.tof_adjust[23]}},
                                                      cfg.tof_adjust});
      if (time_wide[49] != time_wide[48]) begin
         b_time_in = time_wide[49] ? {1'b1, 48'b0} : {1'b0, {48{1'b1}}};
      end else begin
         b_time_in = time_wide[48:0];
      end
      diff_wide = {1'b0, a_ff.tb} - {1'b0, a_ff.ta};
      if ((&diff_wide[48:24]) || !(|diff_wide[48:24])) begin
         b_diff_in = diff_wide[24:0];
      end else begin
         b_diff_in = diff_wide[48] ? {1'b1, 24'b0} : {1'b0, {24{1'b1}}};
      end
   end

   // Products, each registered before use
   assign c_tot_prod_in = b_sum_tot_ff * cfg.tot_gain;
   assign c_pos_prod_in = $signed(b_diff_ff) * $signed({1'b0, cfg.light_velocity});

   // Scale down, add offset, saturate position
   always_comb begin
      tot_shift  = c_tot_prod_ff[44:17];
      // 28-bit unsigned plus 24-bit signed always fits in 32 bits
      out_tot_in = 32'($signed({4'b0, tot_shift})
                       + $signed({{8{cfg.tot_offset[23]}}, cfg.tot_offset}));
      pos_shift  = c_pos_prod_ff[41:9];
      if (pos_shift[32] != pos_shift[31]) begin
         out_pos_in = pos_shift[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         out_pos_in = pos_shift[31:0];
      end
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= pair_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= c_valid_ff;
         end
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_ff <= pair;
      end
      if (b_ready) begin
         b_time_ff    <= b_time_in;
         b_diff_ff    <= b_diff_in;
         b_sum_tot_ff <= a_ff.sum_tot;
      end
      if (c_ready) begin
         c_time_ff     <= b_time_ff;
         c_diff_ff     <= b_diff_ff;
         c_tot_prod_ff <= c_tot_prod_in;
         c_pos_prod_ff <= c_pos_prod_in;
      end
      if (out_ready) begin
         out_time_ff <= c_time_ff;
         out_diff_ff <= c_diff_ff;
         out_tot_ff  <= out_tot_in;
         out_pos_ff  <= out_pos_in;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_hit_time            = $signed(out_time_ff);
   assign rsp_end_time_difference = $signed(out_diff_ff);
   assign rsp_hit_tot             = $signed(out_tot_ff);
   assign rsp_axial_position      = $signed(out_pos_ff);

endmodule
